@@ rtl/core/fsfp_pkg.sv @@
// Shared types and constants for the format-spec field parser.
`default_nettype none

package fsfp_pkg;

  // Saturation bound for width, precision and character count
  localparam int unsigned NUM_BITS = 16;
  localparam logic [15:0] SAT_MAX  = (NUM_BITS >= 16) ? 16'hFFFF
                                                      : 16'((1 << NUM_BITS) - 1);

  // Parse phase codes
  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_BRACE   = 4'd1;
  localparam logic [3:0] PH_COLON   = 4'd2;
  localparam logic [3:0] PH_HELD    = 4'd3;
  localparam logic [3:0] PH_ALIGN   = 4'd4;
  localparam logic [3:0] PH_SIGN    = 4'd5;
  localparam logic [3:0] PH_HASH    = 4'd6;
  localparam logic [3:0] PH_ZERO    = 4'd7;
  localparam logic [3:0] PH_WSTART  = 4'd8;
  localparam logic [3:0] PH_WDIGITS = 4'd9;
  localparam logic [3:0] PH_DOT     = 4'd10;
  localparam logic [3:0] PH_PSTART  = 4'd11;
  localparam logic [3:0] PH_PDIGITS = 4'd12;
  localparam logic [3:0] PH_TYPE    = 4'd13;
  localparam logic [3:0] PH_CLOSE   = 4'd14;

  // Internal decision codes of one parse step
  localparam logic [1:0] R_NONE = 2'd0;
  localparam logic [1:0] R_OK   = 2'd1;
  localparam logic [1:0] R_ERR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_END = 2'd2;

  // Alignment codes
  localparam logic [1:0] AL_NONE   = 2'd0;
  localparam logic [1:0] AL_LEFT   = 2'd1;
  localparam logic [1:0] AL_RIGHT  = 2'd2;
  localparam logic [1:0] AL_CENTER = 2'd3;

  // Sign mode codes
  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_SPACE = 2'd2;

  // Presentation codes
  localparam logic [2:0] KIND_DEF  = 3'd0;
  localparam logic [2:0] KIND_DEC  = 3'd1;
  localparam logic [2:0] KIND_HEX  = 3'd2;
  localparam logic [2:0] KIND_HEXU = 3'd3;
  localparam logic [2:0] KIND_BIN  = 3'd4;
  localparam logic [2:0] KIND_OCT  = 3'd5;
  localparam logic [2:0] KIND_PTR  = 3'd6;
  localparam logic [2:0] KIND_DBG  = 3'd7;

  // Flag bit positions
  localparam int unsigned FL_ALT   = 0;
  localparam int unsigned FL_ZERO  = 1;
  localparam int unsigned FL_WIDTH = 2;
  localparam int unsigned FL_PREC  = 3;

  // Character constants
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_O   = 8'h6F;
  localparam logic [7:0] CH_LO_P   = 8'h70;
  localparam logic [7:0] CH_QUEST  = 8'h3F;

  // One input transaction
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       empty_string;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fill_char;
    logic [1:0]  alignment;
    logic [1:0]  sign_mode;
    logic        alternate_form;
    logic        zero_padding;
    logic        has_min_width;
    logic [15:0] min_width;
    logic        has_prec;
    logic [15:0] prec_value;
    logic [2:0]  present_kind;
    logic [15:0] consumed_count;
  } res_t;

  // Parser state
  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  held;
    logic [7:0]  fill;
    logic [1:0]  align;
    logic [1:0]  sign;
    logic [3:0]  flags;
    logic [15:0] width;
    logic [15:0] prec;
    logic [2:0]  present;
    logic [15:0] count;
    logic        decided;
  } pstate_t;

  localparam pstate_t PSTATE_CLEAR = '{
    phase:   PH_START,
    held:    8'h00,
    fill:    CH_SPACE,
    align:   AL_NONE,
    sign:    SG_NONE,
    flags:   4'h0,
    width:   16'h0000,
    prec:    16'h0000,
    present: KIND_DEF,
    count:   16'h0000,
    decided: 1'b0
  };

endpackage

`default_nettype wire

@@ rtl/core/fsfp_in_skid.sv @@
// Input register with a one-entry skid stage for the parser.
`default_nettype none

module fsfp_in_skid import fsfp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t item_i,
  input  wire logic     take_i,
  output logic          item_valid_o,
  output in_item_t      item_o
);

  logic     a_valid_q, a_valid_d;
  logic     skid_valid_q, skid_valid_d;
  in_item_t a_q, skid_q;
  logic     in_acc, a_load_in, a_load_skid, skid_load;

  // Stall only while the skid entry is occupied
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  // Route incoming transactions to the main or skid entry
  always_comb begin
    a_valid_d    = a_valid_q;
    skid_valid_d = skid_valid_q;
    a_load_in    = 1'b0;
    a_load_skid  = 1'b0;
    skid_load    = 1'b0;
    if (skid_valid_q) begin
      if (take_i) begin
        a_load_skid  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!a_valid_q || take_i) begin
        a_load_in = 1'b1;
        a_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take_i) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      a_valid_q    <= a_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payloads until replaced
  always_ff @(posedge clk_i) begin
    if (a_load_in) begin
      a_q <= item_i;
    end else if (a_load_skid) begin
      a_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= item_i;
    end
  end

  assign item_valid_o = a_valid_q;
  assign item_o       = a_q;

endmodule

`default_nettype wire

@@ rtl/core/fsfp_parse.sv @@
// Parse state, combinational parse step and result register.
`default_nettype none

module fsfp_parse import fsfp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     item_valid_i,
  input  wire in_item_t item_i,
  output logic          take_o,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output res_t          out_o
);

  typedef struct packed {
    pstate_t    s;
    logic [1:0] r;
  } feed_t;

  typedef struct packed {
    pstate_t s;
    logic    emit;
    res_t    res;
  } step_t;

  function automatic logic [15:0] bump(logic [15:0] cnt);
    return (cnt == SAT_MAX) ? cnt : cnt + 16'd1;
  endfunction

  // Multiply by ten and add a digit, saturating
  function automatic logic [15:0] acc_digit(logic [15:0] acc, logic [3:0] d);
    logic [19:0] w;
    w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
    if (w > {4'b0, SAT_MAX}) begin
      return SAT_MAX;
    end
    return w[15:0];
  endfunction

  function automatic logic [1:0] align_code(logic [7:0] c);
    logic [1:0] a;
    a = AL_NONE;
    if (c == CH_LT) begin
      a = AL_LEFT;
    end else if (c == CH_GT) begin
      a = AL_RIGHT;
    end else if (c == CH_CARET) begin
      a = AL_CENTER;
    end
    return a;
  endfunction

  function automatic logic [2:0] kind_code(logic [7:0] c);
    logic [2:0] k;
    unique case (c)
      CH_LO_D:  k = KIND_DEC;
      CH_LO_X:  k = KIND_HEX;
      CH_UP_X:  k = KIND_HEXU;
      CH_LO_B:  k = KIND_BIN;
      CH_LO_O:  k = KIND_OCT;
      CH_LO_P:  k = KIND_PTR;
      CH_QUEST: k = KIND_DBG;
      default:  k = KIND_DEF;
    endcase
    return k;
  endfunction

  // Offer one byte; it is consumed, skips optional phases, or decides
  function automatic feed_t feed(pstate_t s, logic [7:0] c);
    feed_t      f;
    logic [3:0] p;
    logic [1:0] al;
    logic [2:0] kd;
    logic [3:0] dv;
    logic       dec, in_flags, t_align, t_sign, t_hash, t_zero;
    logic       t_wfirst, t_wmore, to_dot, to_type;
    f        = '{s: s, r: R_NONE};
    p        = s.phase;
    al       = align_code(c);
    kd       = kind_code(c);
    dec      = (c >= CH_0) && (c <= CH_9);
    dv       = 4'(c - CH_0);
    in_flags = (p >= PH_ALIGN) && (p <= PH_WSTART);
    t_align  = (p == PH_ALIGN) && (al != AL_NONE);
    t_sign   = in_flags && (p <= PH_SIGN) && ((c == CH_PLUS) || (c == CH_SPACE));
    t_hash   = in_flags && (p <= PH_HASH) && (c == CH_HASH);
    t_zero   = in_flags && (p <= PH_ZERO) && (c == CH_0);
    t_wfirst = in_flags && dec && !t_zero;
    t_wmore  = (p == PH_WDIGITS) && dec;
    to_dot   = (in_flags && !t_align && !t_sign && !t_hash && !t_zero && !t_wfirst)
            || ((p == PH_WDIGITS) && !dec) || (p == PH_DOT);
    to_type  = (to_dot && (c != CH_DOT)) || ((p == PH_PDIGITS) && !dec)
            || (p == PH_TYPE);

    priority if (p == PH_START) begin
      if (c == CH_LBRACE) begin
        f.s.count = bump(s.count);
        f.s.phase = PH_BRACE;
      end else begin
        f.r = R_ERR;
      end
    end else if (p == PH_BRACE) begin
      if (c == CH_RBRACE) begin
        f.s.count = bump(s.count);
        f.r       = R_OK;
      end else if (c == CH_COLON) begin
        f.s.count = bump(s.count);
        f.s.phase = PH_COLON;
      end else begin
        f.r = R_ERR;
      end
    end else if (p == PH_COLON) begin
      f.s.held  = c;
      f.s.phase = PH_HELD;
    end else if (t_align) begin
      f.s.align = al;
      f.s.count = bump(s.count);
      f.s.phase = PH_SIGN;
    end else if (t_sign) begin
      f.s.sign  = (c == CH_PLUS) ? SG_PLUS : SG_SPACE;
      f.s.count = bump(s.count);
      f.s.phase = PH_HASH;
    end else if (t_hash) begin
      f.s.flags[FL_ALT] = 1'b1;
      f.s.count         = bump(s.count);
      f.s.phase         = PH_ZERO;
    end else if (t_zero) begin
      f.s.flags[FL_ZERO] = 1'b1;
      f.s.count          = bump(s.count);
      f.s.phase          = PH_WSTART;
    end else if (t_wfirst) begin
      f.s.flags[FL_WIDTH] = 1'b1;
      f.s.width           = {12'b0, dv};
      f.s.count           = bump(s.count);
      f.s.phase           = PH_WDIGITS;
    end else if (t_wmore) begin
      f.s.width = acc_digit(s.width, dv);
      f.s.count = bump(s.count);
    end else if (to_dot && (c == CH_DOT)) begin
      f.s.flags[FL_PREC] = 1'b1;
      f.s.count          = bump(s.count);
      f.s.phase          = PH_PSTART;
    end else if (p == PH_PSTART) begin
      if (dec) begin
        f.s.prec  = {12'b0, dv};
        f.s.count = bump(s.count);
        f.s.phase = PH_PDIGITS;
      end else begin
        f.r = R_ERR;
      end
    end else if ((p == PH_PDIGITS) && dec) begin
      f.s.prec  = acc_digit(s.prec, dv);
      f.s.count = bump(s.count);
    end else if (to_type) begin
      if (c == CH_RBRACE) begin
        f.s.count = bump(s.count);
        f.s.phase = PH_CLOSE;
        f.r       = R_OK;
      end else if (kd != KIND_DEF) begin
        f.s.present = kd;
        f.s.count   = bump(s.count);
        f.s.phase   = PH_CLOSE;
      end else begin
        f.r = R_ERR;
      end
    end else if (p == PH_CLOSE) begin
      if (c == CH_RBRACE) begin
        f.s.count = bump(s.count);
        f.r       = R_OK;
      end else begin
        f.r = R_ERR;
      end
    end else begin
      f.r = R_ERR;
    end
    return f;
  endfunction

  // Full step for one transaction, including the fill lookahead
  function automatic step_t step(pstate_t s, in_item_t it);
    step_t      o;
    pstate_t    sh;
    feed_t      f1, f2;
    logic [1:0] al, r;
    o.s    = s;
    o.emit = 1'b0;
    o.res  = '0;
    f1     = '{s: s, r: R_NONE};
    f2     = f1;
    al     = align_code(it.character);
    sh     = s;
    sh.phase = PH_ALIGN;
    if (it.empty_string) begin
      o.emit       = 1'b1;
      o.res.status = ST_END;
      o.s          = PSTATE_CLEAR;
    end else if (s.decided) begin
      if (it.last_char) begin
        o.s = PSTATE_CLEAR;
      end
    end else begin
      if ((s.phase == PH_HELD) && (al != AL_NONE)) begin
        // Held byte is a fill byte
        f2.s.fill  = s.held;
        f2.s.align = al;
        f2.s.count = bump(bump(s.count));
        f2.s.phase = PH_SIGN;
      end else if (s.phase == PH_HELD) begin
        f1 = feed(sh, s.held);
        f2 = (f1.r == R_NONE) ? feed(f1.s, it.character) : f1;
      end else begin
        f1 = feed(s, it.character);
        if (it.last_char && (f1.r == R_NONE) && (f1.s.phase == PH_HELD)) begin
          // Flush the held byte at string end
          sh       = f1.s;
          sh.phase = PH_ALIGN;
          f2       = feed(sh, f1.s.held);
        end else begin
          f2 = f1;
        end
      end
      r = (it.last_char && (f2.r == R_NONE)) ? R_ERR : f2.r;
      o.s = f2.s;
      if (r != R_NONE) begin
        o.emit = 1'b1;
        if (r == R_OK) begin
          o.res.status         = ST_OK;
          o.res.fill_char      = f2.s.fill;
          o.res.alignment      = f2.s.align;
          o.res.sign_mode      = f2.s.sign;
          o.res.alternate_form = f2.s.flags[FL_ALT];
          o.res.zero_padding   = f2.s.flags[FL_ZERO];
          o.res.has_min_width  = f2.s.flags[FL_WIDTH];
          o.res.min_width      = f2.s.width;
          o.res.has_prec       = f2.s.flags[FL_PREC];
          o.res.prec_value     = f2.s.prec;
          o.res.present_kind   = f2.s.present;
          o.res.consumed_count = f2.s.count;
        end else begin
          o.res.status = ST_ERR;
        end
        if (it.last_char) begin
          o.s = PSTATE_CLEAR;
        end else begin
          o.s.decided = 1'b1;
        end
      end
    end
    return o;
  endfunction

  pstate_t state_q;
  step_t   st;
  logic    out_valid_q, out_valid_d, out_free;
  res_t    res_q;

  assign st       = step(state_q, item_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign take_o   = item_valid_i && out_free;

  // Advance the result slot when it is free
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = take_o && st.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PSTATE_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        state_q <= st.s;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (take_o && st.emit) begin
      res_q <= st.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/core/format_spec_field_parser.sv @@
// Top level of the format-spec replacement field parser.
// A deciding transaction passes the input register, then the result register.
// Throughput: one character per cycle unless the result side stalls; the parse
//   step is one pass of logic between the input register and the result register.
// Reset: rst_ni clears the parser to wait for an opening brace and empties
//   both the input and result registers; no clearing pass is needed.
`default_nettype none

module format_spec_field_parser import fsfp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  character_i,
  input  wire logic        last_char_i,
  input  wire logic        empty_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       fill_char_o,
  output logic [1:0]       alignment_o,
  output logic [1:0]       sign_mode_o,
  output logic             alternate_form_o,
  output logic             zero_padding_o,
  output logic             has_min_width_o,
  output logic [15:0]      min_width_o,
  output logic             has_prec_o,
  output logic [15:0]      prec_value_o,
  output logic [2:0]       present_kind_o,
  output logic [15:0]      consumed_count_o
);

  in_item_t in_item, item;
  logic     item_valid, take;
  res_t     res;

  assign in_item = '{character: character_i, last_char: last_char_i,
                     empty_string: empty_string_i};

  fsfp_in_skid u_in_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fsfp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_o        (res)
  );

  // Unpack the result transaction
  assign status_o         = res.status;
  assign fill_char_o      = res.fill_char;
  assign alignment_o      = res.alignment;
  assign sign_mode_o      = res.sign_mode;
  assign alternate_form_o = res.alternate_form;
  assign zero_padding_o   = res.zero_padding;
  assign has_min_width_o  = res.has_min_width;
  assign min_width_o      = res.min_width;
  assign has_prec_o       = res.has_prec;
  assign prec_value_o     = res.prec_value;
  assign present_kind_o   = res.present_kind;
  assign consumed_count_o = res.consumed_count;

endmodule

`default_nettype wire

@@ tb/sv/tb_format_spec_field_parser.sv @@
// Self-checking testbench for the format-spec field parser, with a built-in predictor.
module tb_format_spec_field_parser;
  import fsfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_CHARS = 1200;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PRINT_LIMIT  = 40;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  character_i    = 8'h00;
  logic        last_char_i    = 1'b0;
  logic        empty_string_i = 1'b0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  fill_char_o;
  logic [1:0]  alignment_o;
  logic [1:0]  sign_mode_o;
  logic        alternate_form_o;
  logic        zero_padding_o;
  logic        has_min_width_o;
  logic [15:0] min_width_o;
  logic        has_prec_o;
  logic [15:0] prec_value_o;
  logic [2:0]  present_kind_o;
  logic [15:0] consumed_count_o;

  // Predictor state and bookkeeping
  pstate_t     parse_st = PSTATE_CLEAR;
  res_t        expected_specs[$];
  logic [7:0]  field_text[$];
  bit          in_idle_on   = 1'b1;
  bit          out_pause_on = 1'b1;
  int unsigned chars_parsed;
  int unsigned results_seen;
  int unsigned ok_seen;
  int unsigned err_seen;
  int unsigned end_seen;
  int unsigned mismatches;
  int unsigned cycle_count;

  format_spec_field_parser uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .character_i      (character_i),
    .last_char_i      (last_char_i),
    .empty_string_i   (empty_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .fill_char_o      (fill_char_o),
    .alignment_o      (alignment_o),
    .sign_mode_o      (sign_mode_o),
    .alternate_form_o (alternate_form_o),
    .zero_padding_o   (zero_padding_o),
    .has_min_width_o  (has_min_width_o),
    .min_width_o      (min_width_o),
    .has_prec_o       (has_prec_o),
    .prec_value_o     (prec_value_o),
    .present_kind_o   (present_kind_o),
    .consumed_count_o (consumed_count_o)
  );

  // Run the clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= out_pause_on && ($urandom_range(99) < 38);
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [1:0] align_of(logic [7:0] c);
    case (c)
      CH_LT:    return AL_LEFT;
      CH_GT:    return AL_RIGHT;
      CH_CARET: return AL_CENTER;
      default:  return AL_NONE;
    endcase
  endfunction

  function automatic logic [2:0] kind_of(logic [7:0] c);
    case (c)
      CH_LO_D: return KIND_DEC;
      CH_LO_X: return KIND_HEX;
      CH_UP_X: return KIND_HEXU;
      CH_LO_B: return KIND_BIN;
      CH_LO_O: return KIND_OCT;
      CH_LO_P: return KIND_PTR;
      CH_QUEST: return KIND_DBG;
      default: return KIND_DEF;
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Accumulate one decimal digit, saturating
  function automatic logic [15:0] digit_acc(logic [15:0] acc, logic [7:0] c);
    int unsigned d;
    int unsigned lim;
    d   = c - CH_0;
    lim = SAT_MAX;
    if (acc > (lim - d) / 10) return SAT_MAX;
    return 16'(acc * 10 + d);
  endfunction

  function automatic void count_up();
    if (parse_st.count < SAT_MAX) parse_st.count = parse_st.count + 16'd1;
  endfunction

  // Offer one byte to the field grammar; consume it, pass it on, or decide
  function automatic logic [1:0] parse_byte(logic [7:0] c);
    logic [1:0] a;
    logic [2:0] k;
    while (1'b1) begin
      case (parse_st.phase)
        PH_START: begin
          if (c == CH_LBRACE) begin
            count_up();
            parse_st.phase = PH_BRACE;
            return R_NONE;
          end
          return R_ERR;
        end
        PH_BRACE: begin
          if (c == CH_RBRACE) begin
            count_up();
            return R_OK;
          end
          if (c == CH_COLON) begin
            count_up();
            parse_st.phase = PH_COLON;
            return R_NONE;
          end
          return R_ERR;
        end
        PH_COLON: begin
          parse_st.held  = c;
          parse_st.phase = PH_HELD;
          return R_NONE;
        end
        PH_ALIGN: begin
          a = align_of(c);
          parse_st.phase = PH_SIGN;
          if (a != AL_NONE) begin
            parse_st.align = a;
            count_up();
            return R_NONE;
          end
        end
        PH_SIGN: begin
          parse_st.phase = PH_HASH;
          if (c == CH_PLUS || c == CH_SPACE) begin
            parse_st.sign = (c == CH_PLUS) ? SG_PLUS : SG_SPACE;
            count_up();
            return R_NONE;
          end
        end
        PH_HASH: begin
          parse_st.phase = PH_ZERO;
          if (c == CH_HASH) begin
            parse_st.flags[FL_ALT] = 1'b1;
            count_up();
            return R_NONE;
          end
        end
        PH_ZERO: begin
          parse_st.phase = PH_WSTART;
          if (c == CH_0) begin
            parse_st.flags[FL_ZERO] = 1'b1;
            count_up();
            return R_NONE;
          end
        end
        PH_WSTART, PH_WDIGITS: begin
          if (is_digit(c)) begin
            if (parse_st.phase == PH_WSTART) begin
              parse_st.flags[FL_WIDTH] = 1'b1;
              parse_st.width = 16'h0000;
            end
            parse_st.width = digit_acc(parse_st.width, c);
            count_up();
            parse_st.phase = PH_WDIGITS;
            return R_NONE;
          end
          parse_st.phase = PH_DOT;
        end
        PH_DOT: begin
          if (c == CH_DOT) begin
            parse_st.flags[FL_PREC] = 1'b1;
            count_up();
            parse_st.phase = PH_PSTART;
            return R_NONE;
          end
          parse_st.phase = PH_TYPE;
        end
        PH_PSTART, PH_PDIGITS: begin
          if (is_digit(c)) begin
            if (parse_st.phase == PH_PSTART) parse_st.prec = 16'h0000;
            parse_st.prec = digit_acc(parse_st.prec, c);
            count_up();
            parse_st.phase = PH_PDIGITS;
            return R_NONE;
          end
          // a dot needs at least one digit
          if (parse_st.phase == PH_PSTART) return R_ERR;
          parse_st.phase = PH_TYPE;
        end
        PH_TYPE: begin
          if (c == CH_RBRACE) begin
            parse_st.phase = PH_CLOSE;
          end else begin
            k = kind_of(c);
            if (k == KIND_DEF) return R_ERR;
            parse_st.present = k;
            count_up();
            parse_st.phase = PH_CLOSE;
            return R_NONE;
          end
        end
        PH_CLOSE: begin
          if (c == CH_RBRACE) begin
            count_up();
            return R_OK;
          end
          return R_ERR;
        end
        default: return R_ERR;
      endcase
    end
    return R_ERR;
  endfunction

  // Advance the predictor by one accepted transaction; queue any result
  function automatic void predict_step(logic [7:0] c, logic last, logic empty);
    logic [1:0] r;
    logic [1:0] a;
    res_t       res;
    r   = R_NONE;
    res = '0;
    if (empty) begin
      res.status = ST_END;
      expected_specs.push_back(res);
      parse_st = PSTATE_CLEAR;
      return;
    end
    // drop bytes after a decision; the last one rearms the parser
    if (parse_st.decided) begin
      if (last) parse_st = PSTATE_CLEAR;
      return;
    end
    if (parse_st.phase == PH_HELD) begin
      a = align_of(c);
      if (a != AL_NONE) begin
        parse_st.fill  = parse_st.held;
        parse_st.align = a;
        count_up();
        count_up();
        parse_st.phase = PH_SIGN;
      end else begin
        parse_st.phase = PH_ALIGN;
        r = parse_byte(parse_st.held);
        if (r == R_NONE) r = parse_byte(c);
      end
    end else begin
      r = parse_byte(c);
    end
    if (last && r == R_NONE && parse_st.phase == PH_HELD) begin
      parse_st.phase = PH_ALIGN;
      r = parse_byte(parse_st.held);
    end
    if (last && r == R_NONE) r = R_ERR;
    if (r == R_NONE) return;
    if (r == R_ERR) begin
      res.status = ST_ERR;
    end else begin
      res.status         = ST_OK;
      res.fill_char      = parse_st.fill;
      res.alignment      = parse_st.align;
      res.sign_mode      = parse_st.sign;
      res.alternate_form = parse_st.flags[FL_ALT];
      res.zero_padding   = parse_st.flags[FL_ZERO];
      res.has_min_width  = parse_st.flags[FL_WIDTH];
      res.min_width      = parse_st.width;
      res.has_prec       = parse_st.flags[FL_PREC];
      res.prec_value     = parse_st.prec;
      res.present_kind   = parse_st.present;
      res.consumed_count = parse_st.count;
    end
    expected_specs.push_back(res);
    if (last) parse_st = PSTATE_CLEAR;
    else parse_st.decided = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("[%0d] MISMATCH %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d: %s got 0x%0h expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_specs.size() == 0) begin
        report_mismatch($sformatf("unexpected result with status %0d", status_o));
      end else begin
        want = expected_specs.pop_front();
        check_field("status", status_o, want.status);
        check_field("fill_char", fill_char_o, want.fill_char);
        check_field("alignment", alignment_o, want.alignment);
        check_field("sign_mode", sign_mode_o, want.sign_mode);
        check_field("alternate_form", alternate_form_o, want.alternate_form);
        check_field("zero_padding", zero_padding_o, want.zero_padding);
        check_field("has_min_width", has_min_width_o, want.has_min_width);
        check_field("min_width", min_width_o, want.min_width);
        check_field("has_prec", has_prec_o, want.has_prec);
        check_field("prec_value", prec_value_o, want.prec_value);
        check_field("present_kind", present_kind_o, want.present_kind);
        check_field("consumed_count", consumed_count_o, want.consumed_count);
        case (want.status)
          ST_OK:   ok_seen++;
          ST_ERR:  err_seen++;
          default: end_seen++;
        endcase
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Send one character transaction; called and returns at a falling edge
  task automatic send_char(logic [7:0] c, logic last, logic empty);
    while (in_idle_on && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    character_i    <= c;
    last_char_i    <= last;
    empty_string_i <= empty;
    do @(posedge clk_i); while (in_stall_o);
    if (empty || !parse_st.decided) chars_parsed++;
    predict_step(c, last, empty);
    @(negedge clk_i);
  endtask

  task automatic add_byte(logic [7:0] b);
    field_text.push_back(b);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) field_text.push_back(s[i]);
  endtask

  // Send the buffered text as one string; optionally cut it with an empty item
  task automatic send_text(int empty_at);
    for (int i = 0; i < field_text.size(); i++) begin
      if (i == empty_at) begin
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        break;
      end
      send_char(field_text[i], i == field_text.size() - 1, 1'b0);
    end
    field_text.delete();
  endtask

  task automatic send_str(string s);
    add_str(s);
    send_text(-1);
  endtask

  function automatic logic [7:0] align_mark(int unsigned i);
    case (i)
      0:       return CH_LT;
      1:       return CH_GT;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] type_mark(int unsigned i);
    case (i)
      0:       return CH_LO_D;
      1:       return CH_LO_X;
      2:       return CH_UP_X;
      3:       return CH_LO_B;
      4:       return CH_LO_O;
      5:       return CH_LO_P;
      default: return CH_QUEST;
    endcase
  endfunction

  task automatic add_digits(int unsigned n);
    repeat (n) add_byte(8'(CH_0 + $urandom_range(9)));
  endtask

  // Build a mostly well-formed field with random content
  task automatic build_random_field();
    add_byte(CH_LBRACE);
    if ($urandom_range(9) == 0) begin
      add_byte(CH_RBRACE);
      return;
    end
    add_byte(CH_COLON);
    case ($urandom_range(3))
      0: begin
        add_byte(8'($urandom_range(255)));
        add_byte(align_mark($urandom_range(2)));
      end
      1: add_byte(align_mark($urandom_range(2)));
      default: ;
    endcase
    case ($urandom_range(2))
      0: add_byte(CH_PLUS);
      1: add_byte(CH_SPACE);
      default: ;
    endcase
    if ($urandom_range(2) == 0) add_byte(CH_HASH);
    if ($urandom_range(2) == 0) add_byte(CH_0);
    if ($urandom_range(15) == 0) add_digits($urandom_range(5, 7));
    else add_digits($urandom_range(3));
    if ($urandom_range(4) < 3) begin
      add_byte(CH_DOT);
      if ($urandom_range(15) == 0) add_digits($urandom_range(5, 7));
      else if ($urandom_range(9) != 0) add_digits($urandom_range(1, 3));
    end
    case ($urandom_range(19))
      0:       add_byte(8'($urandom_range(255)));
      1, 2, 3, 4, 5: ;
      default: add_byte(type_mark($urandom_range(6)));
    endcase
    if ($urandom_range(19) != 0) add_byte(CH_RBRACE);
  endtask

  task automatic test_basic_fields();
    send_str("{}");
    send_str("{:}");
    send_str("{:<}");
    send_str("{:*^10}");
    send_str("{:>+#08.3x}");
    send_str("{: d}");
    send_str("{:0}");
    send_str("{:010}");
    // extreme fill bytes ahead of an align mark
    add_str("{:");
    add_byte(8'hFF);
    add_str(">7}");
    send_text(-1);
    add_str("{:");
    add_byte(8'h00);
    add_str("<}");
    send_text(-1);
  endtask

  task automatic test_presentations();
    send_str("{:d}");
    send_str("{:x}");
    send_str("{:X}");
    send_str("{:b}");
    send_str("{:o}");
    send_str("{:p}");
    send_str("{:.2?}");
  endtask

  task automatic test_error_paths();
    send_str("{:.}");
    send_str("{:q}");
    send_str("{:5");
    send_str("{:");
    send_str("{:<");
    send_str("x{}");
    send_str("{{");
  endtask

  task automatic test_empty_and_trailing();
    send_char(8'hFF, 1'b1, 1'b1);
    add_str("{:5#");
    send_text(3);
    send_str("{}abc");
    send_str("{:}}");
  endtask

  // Saturate width and precision
  task automatic test_saturation();
    send_str("{:99999999}");
    send_str("{:.123456}");
  endtask

  task automatic test_random_fields();
    int unsigned start;
    int unsigned sel;
    int          empty_at;
    start = chars_parsed;
    while (chars_parsed - start < RANDOM_CHARS) begin
      // hold a stretch with no idling on either side
      in_idle_on   = (chars_parsed - start < 600) || (chars_parsed - start > 900);
      out_pause_on = in_idle_on;
      sel      = $urandom_range(99);
      empty_at = -1;
      if (sel < 75) begin
        build_random_field();
        if ($urandom_range(9) == 0) begin
          sel = $urandom_range(1, field_text.size());
          while (field_text.size() > sel) void'(field_text.pop_back());
        end
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4))
          add_byte(8'($urandom_range(255)));
        if ($urandom_range(19) == 0) empty_at = $urandom_range(field_text.size() - 1);
        send_text(empty_at);
      end else if (sel < 92) begin
        if ($urandom_range(1) == 0) add_byte(CH_LBRACE);
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        send_text(-1);
      end else begin
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
    end
    in_idle_on   = 1'b1;
    out_pause_on = 1'b1;
  endtask

  // Stop a hung run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_specs.size());
    $display("** format_spec_field_parser: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_fields();
    test_presentations();
    test_error_paths();
    test_empty_and_trailing();
    test_saturation();
    test_random_fields();

    in_valid_i <= 1'b0;
    while (expected_specs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Parsed %0d characters; checked %0d results: %0d ok, %0d error, %0d end.",
             chars_parsed, results_seen, ok_seen, err_seen, end_seen);
    $display("Covered flags, fills, alignments, presentations, saturation, "
             , "truncated, cut and empty strings, %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_specs.size() == 0) begin
      $display("** format_spec_field_parser: PASSED **");
    end else begin
      $display("** format_spec_field_parser: FAILED **");
    end
    $finish;
  end

endmodule
